// ===== rtl/core/breadth_first_graph_walk_assert.svh =====
// Assertion macros for the breadth-first graph walk RTL.
// Active in simulation; they expand to nothing when SYNTHESIS is defined.
`ifndef BREADTH_FIRST_GRAPH_WALK_ASSERT_SVH
`define BREADTH_FIRST_GRAPH_WALK_ASSERT_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define BFGW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that expr never holds at a clock edge outside reset.
`define BFGW_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define BFGW_ASSERT(label, clk, rst_n, prop, msg)
`define BFGW_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/core/bfgw_pkg.sv =====
// Shared constants, word types and helpers for the breadth-first graph walk.
// No dependencies.
package bfgw_pkg;

	localparam int NODES = 16;
	localparam int IDX_W = $clog2(NODES);
	localparam int CNT_W = $clog2(NODES + 1);

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_RUN  = 1'b1;

	typedef struct packed {
		logic        func;
		logic [3:0]  row_index;
		logic [15:0] row_bits;
		logic [3:0]  start_node;
	} cmd_t;

	typedef struct packed {
		logic [3:0] node;
		logic       last;
	} result_t;

	// Index of the lowest set bit; zero when no bit is set.
	function automatic logic [IDX_W-1:0] lowest_bit(input logic [NODES-1:0] mask);
		logic [IDX_W-1:0] idx;
		idx = '0;
		for (int i = NODES - 1; i >= 0; i--) begin
			if (mask[i]) begin
				idx = IDX_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== rtl/core/breadth_first_graph_walk.sv =====
// Breadth-first graph walk over an adjacency matrix held in on-chip RAM.
// Depends on bfgw_pkg and breadth_first_graph_walk_assert.svh.
//
// Usage:
//   Command channel: drive cmd and raise start; the word is taken at a rising
//   edge with start high and busy low. A load word (func = load) writes one
//   adjacency row and leaves busy low. A run word
//   (func = run) walks the graph from cmd.start_node and holds busy high
//   until the final node has been issued.
//   Result channel: each visited node appears on result for exactly one
//   cycle with result_stb high, in breadth-first order; the final node has
//   result.last set. The receiver cannot stall; every strobe is a word taken.
//   Steps: each reached node passes through queue read, row read, neighbor
//   scan and issue; its new neighbors are enqueued one at a time before the
//   issue, set by the single write port of the queue RAM. The result word is
//   registered and shows in the cycle after the issue step.
//   Reset: adjacency rows read as zero until loaded (per-row valid bits),
//   visited marks and queue pointers clear, busy and result_stb go low.
//   The queue RAM is not cleared: every entry is written before it is read.
`include "breadth_first_graph_walk_assert.svh"

module breadth_first_graph_walk
	import bfgw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    busy,
	output result_t result,
	output logic    result_stb
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEQ   = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_ENQ   = 3'd4;

	logic [2:0]       state_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] tail_q;
	logic [NODES-1:0] visited_q;
	logic [NODES-1:0] pend_q;
	logic [NODES-1:0] row_vld_q;
	logic [IDX_W-1:0] cur_q;
	result_t          res_q;
	logic             stb_q;

	logic [NODES-1:0] adj_mem [NODES];
	logic [IDX_W-1:0] queue_mem [NODES];
	logic [NODES-1:0] adj_rd_q;
	logic [IDX_W-1:0] q_rd_q;

	logic             accept;
	logic             run_ok;
	logic             load_ok;
	logic             q_we;
	logic [IDX_W-1:0] q_waddr;
	logic [IDX_W-1:0] q_wdata;
	logic [IDX_W-1:0] pend_idx;
	logic [NODES-1:0] row;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign run_ok  = ({1'b0, cmd.start_node} < CNT_W'(NODES));
	assign load_ok = ({1'b0, cmd.row_index} < CNT_W'(NODES));
	assign pend_idx = lowest_bit(pend_q);
	assign row = row_vld_q[cur_q] ? adj_rd_q : '0;

	// Steer the queue write port: start node at run, one neighbor per cycle after
	always_comb begin
		q_we    = 1'b0;
		q_waddr = tail_q[IDX_W-1:0];
		q_wdata = pend_idx;
		if (accept && cmd.func == FUNC_RUN && run_ok) begin
			q_we    = 1'b1;
			q_waddr = '0;
			q_wdata = cmd.start_node[IDX_W-1:0];
		end else if (state_q == ST_ENQ && pend_q != '0) begin
			q_we = 1'b1;
		end
	end

	// Adjacency RAM: write on load, registered read at the current node
	always_ff @(posedge clk) begin
		if (accept && cmd.func == FUNC_LOAD && load_ok) begin
			adj_mem[cmd.row_index[IDX_W-1:0]] <= cmd.row_bits[NODES-1:0];
		end
		adj_rd_q <= adj_mem[q_rd_q];
	end

	// Queue RAM: one write, registered read at the head
	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		q_rd_q <= queue_mem[head_q[IDX_W-1:0]];
	end

	// Walk sequencer: mark loaded rows valid; on a run, dequeue, fetch row, scan neighbors, enqueue, issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			tail_q    <= '0;
			visited_q <= '0;
			pend_q    <= '0;
			row_vld_q <= '0;
			cur_q     <= '0;
			stb_q     <= 1'b0;
		end else begin
			// Strobe the word once the last neighbor is enqueued
			stb_q <= (state_q == ST_ENQ) && (pend_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.func == FUNC_LOAD) begin
							if (load_ok) begin
								row_vld_q[cmd.row_index[IDX_W-1:0]] <= 1'b1;
							end
						end else begin
							head_q <= '0;
							if (run_ok) begin
								tail_q    <= CNT_W'(1);
								visited_q <= NODES'(1) << cmd.start_node[IDX_W-1:0];
								state_q   <= ST_DEQ;
							end else begin
								tail_q    <= '0;
								visited_q <= '0;
							end
						end
					end
				end
				ST_DEQ: begin
					head_q  <= head_q + CNT_W'(1);
					state_q <= ST_FETCH;
				end
				ST_FETCH: begin
					cur_q   <= q_rd_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// Mark every new neighbor now; enqueue them lowest first
					pend_q    <= row & ~visited_q;
					visited_q <= visited_q | row;
					state_q   <= ST_ENQ;
				end
				ST_ENQ: begin
					if (pend_q != '0) begin
						pend_q <= pend_q & (pend_q - NODES'(1));
						tail_q <= tail_q + CNT_W'(1);
					end else begin
						state_q <= (head_q == tail_q) ? ST_IDLE : ST_DEQ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result word register
	always_ff @(posedge clk) begin
		if (state_q == ST_ENQ && pend_q == '0) begin
			res_q.node <= 4'(cur_q);
			res_q.last <= (head_q == tail_q);
		end
	end

	assign result     = res_q;
	assign result_stb = stb_q;

	`BFGW_ASSERT(a_last_ends_run, clk, arst_n,
		(result_stb && result.last) |-> (state_q == ST_IDLE),
		"last word issued while walk still running")
	`BFGW_ASSERT(a_more_follows, clk, arst_n,
		(result_stb && !result.last) |-> (state_q == ST_DEQ),
		"non-last word issued but walk not continuing")
	`BFGW_NEVER(a_tail_bound, clk, arst_n, tail_q > CNT_W'(NODES),
		"queue tail beyond node count")
	`BFGW_NEVER(a_head_le_tail, clk, arst_n, head_q > tail_q,
		"queue head passed tail")
	`BFGW_NEVER(a_pend_marked, clk, arst_n,
		(pend_q & ~visited_q) != '0 && state_q == ST_ENQ,
		"pending neighbor not marked visited")

endmodule
